/* src/sphvis_pkg.sv */
`timescale 1ns / 1ps
// shared types, reset values and register codes for the sph pair viscosity unit
// no dependencies

package sphvis_pkg;

    // default fraction width of the fixed-point fields
    localparam int unsigned FRAC_BITS_DEF = 16;

    // register reset values
    localparam logic [30:0] SMOOTH_LEN_RST = 31'd327680;
    localparam logic [31:0] SMOOTH_SQ_RST  = 32'd1638400;
    localparam logic [31:0] GRAD_COEFF_RST = 32'd410140;

    // 0.01 scaled by 2^32, rounded up
    localparam logic [25:0] EPS_SCALE = 26'd42949673;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SMOOTH_LEN  = 2'd0,
        REG_SMOOTH_SQ   = 2'd1,
        REG_GRAD_COEFF  = 2'd2
    } cfg_reg_t;

    // offset magnitudes and signs of the three axes
    typedef struct packed {
        logic [2:0][31:0] ax;
        logic [2:0]       xneg;
    } ofs_t;

    // square root recurrence state
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } sqs_t;

    // distance root and dot coefficient divide run side by side
    typedef struct packed {
        ofs_t        ofs;
        logic        cneg;
        logic        czero;
        logic        csat;
        logic [30:0] nlow;
        logic [63:0] denom;
        logic [63:0] crem;
        logic [30:0] cq;
        logic [63:0] r2;
        sqs_t        sq;
    } bst_t;

    // per item values carried once r and c are known
    typedef struct packed {
        ofs_t        ofs;
        logic [30:0] cmag;
        logic        cneg;
        logic [31:0] r;
        logic        inrange;
    } side_t;

    // q = r / h divide state
    typedef struct packed {
        side_t       side;
        logic [31:0] qrem;
        logic [30:0] q;
    } qst_t;

    // kernel factor divide by r
    typedef struct packed {
        side_t       side;
        logic [31:0] plow;
        logic        ksat;
        logic [31:0] krem;
        logic [31:0] kq;
    } kst_t;

    // finished values waiting for the force norm
    typedef struct packed {
        logic [2:0][31:0] frc;
        logic [30:0]      cmag;
        logic             cneg;
        logic [31:0]      r;
    } tail_t;

    // force norm root state
    typedef struct packed {
        tail_t       tail;
        logic [63:0] f2;
        sqs_t        sq;
    } rst_t;

    // one restoring square root step, two radicand bits in
    function automatic sqs_t sqrt_step(input sqs_t x, input logic [1:0] pair);
        logic [35:0] rem2;
        logic [35:0] trial;
        sqs_t        y;
        rem2  = {x.rem, pair};
        trial = {2'b00, x.root, 2'b01};
        if (rem2 >= trial) begin
            y.rem  = 34'(rem2 - trial);
            y.root = {x.root[30:0], 1'b1};
        end else begin
            y.rem  = rem2[33:0];
            y.root = {x.root[30:0], 1'b0};
        end
        return y;
    endfunction

endpackage

/* src/sph_pair_viscosity_term.sv */
`timescale 1ns / 1ps
// sph pair viscosity term: offsets, distance, dot coefficient, kernel gradient, force norm
// depends on sphvis_pkg
//
//  channel | direction | handshake          | content
//  --------+-----------+--------------------+-------------------------------------------
//  cfg     | in        | cfg_valid/ready    | register index and 32-bit write data
//  s       | in        | s_tvalid/s_tready  | one particle pair per item, 384-bit tdata
//  m       | out       | m_tvalid/m_tready  | force, norm, distance, coefficient, 192-bit
//
// one item per cycle while the skid register is empty, through 142 pipeline stages and
// the output register. most of the stages are the digit recurrences: the distance root
// and the coefficient divide (32 stages), the q divide (32), the kernel divide by r (33)
// and the norm root (32), one bit or one root digit per stage.
// aresetn is synchronous; it clears the valid bits and the output and skid flags and puts
// the configuration registers to their reset values. a stalled output parks one item in
// the skid register; the pipeline freezes only while the skid register is full.

module sph_pair_viscosity_term #(
    parameter int unsigned FRAC_BITS = sphvis_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_pos_x/y/z, second_pos_x/y/z, first_vel_x/y/z, second_vel_x/y/z, 32 bits each
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // force_x/y/z (32 each), force_magnitude (31), distance (31), dot_coeff (32), 2 zero bits
    output logic [191:0] m_tdata
);
    import sphvis_pkg::*;

    localparam int unsigned BST = 32;
    localparam int unsigned QST = 32;
    localparam int unsigned KST = 33;
    localparam int unsigned RST = 32;
    localparam int unsigned NST = 4 + BST + QST + 3 + KST + 6 + RST;
    localparam int unsigned SH_C = 31 - FRAC_BITS;
    localparam int unsigned SH_K = 54 - 2 * FRAC_BITS;
    localparam int unsigned SH_E = 32 - FRAC_BITS;

    // saturated difference, returned as sign and magnitude
    function automatic logic [32:0] sub_mag(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        logic [31:0] s;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31]) s = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else s = d[31:0];
        return {s[31], s[31] ? (~s + 32'd1) : s};
    endfunction

    // root digit and coefficient quotient bit
    function automatic bst_t b_step(input bst_t x, input int unsigned k);
        logic [64:0] rem2;
        bst_t        y;
        y    = x;
        y.sq = sqrt_step(x.sq, x.r2[6'(63 - 2 * k) -: 2]);
        rem2 = {x.crem, x.nlow[5'(31 - k)]};
        if (rem2 >= {1'b0, x.denom}) begin
            y.crem = 64'(rem2 - {1'b0, x.denom});
            y.cq   = {x.cq[29:0], 1'b1};
        end else begin
            y.crem = rem2[63:0];
            y.cq   = {x.cq[29:0], 1'b0};
        end
        return y;
    endfunction

    // q quotient bit
    function automatic qst_t q_step(input qst_t x, input logic nbit, input logic [30:0] h);
        logic [32:0] rem2;
        qst_t        y;
        y    = x;
        rem2 = {x.qrem, nbit};
        if (rem2 >= {2'b00, h}) begin
            y.qrem = 32'(rem2 - {2'b00, h});
            y.q    = {x.q[29:0], 1'b1};
        end else begin
            y.qrem = rem2[31:0];
            y.q    = {x.q[29:0], 1'b0};
        end
        return y;
    endfunction

    // kernel factor quotient bit
    function automatic kst_t k_step(input kst_t x, input int unsigned k);
        logic [32:0] rem2;
        kst_t        y;
        y    = x;
        rem2 = {x.krem, x.plow[5'(32 - k)]};
        if (rem2 >= {1'b0, x.side.r}) begin
            y.krem = 32'(rem2 - {1'b0, x.side.r});
            y.kq   = {x.kq[30:0], 1'b1};
        end else begin
            y.krem = rem2[31:0];
            y.kq   = {x.kq[30:0], 1'b0};
        end
        return y;
    endfunction

    logic [30:0] h_reg;
    logic [31:0] hsq_reg;
    logic [31:0] gc_reg;
    logic [57:0] eps_prod;
    logic [63:0] eps_reg;

    logic           pipe_en;
    logic           pipe_out;
    logic [NST-1:0] vld_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg   <= SMOOTH_LEN_RST;
            hsq_reg <= SMOOTH_SQ_RST;
            gc_reg  <= GRAD_COEFF_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SMOOTH_LEN: h_reg   <= cfg_data[30:0];
                REG_SMOOTH_SQ:  hsq_reg <= cfg_data;
                REG_GRAD_COEFF: gc_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // softening term 0.01 h^2 with doubled fraction bits
    assign eps_prod = hsq_reg * EPS_SCALE;

    always_ff @(posedge aclk) begin
        eps_reg <= 64'(eps_prod >> SH_E);
    end

    // valid bits travel with the items
    assign s_tready = pipe_en;
    assign pipe_out = pipe_en && vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // stage 1: saturated offsets
    logic [2:0][32:0] s1_x;
    logic [2:0][32:0] s1_v;
    logic [2:0][31:0] s1_ax_reg, s1_av_reg;
    logic [2:0]       s1_xneg_reg, s1_diff_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s1_x[i] = sub_mag(s_tdata[32*i +: 32], s_tdata[32*(3+i) +: 32]);
            s1_v[i] = sub_mag(s_tdata[32*(6+i) +: 32], s_tdata[32*(9+i) +: 32]);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                s1_ax_reg[i]   <= s1_x[i][31:0];
                s1_av_reg[i]   <= s1_v[i][31:0];
                s1_xneg_reg[i] <= s1_x[i][32];
                s1_diff_reg[i] <= s1_x[i][32] != s1_v[i][32];
            end
        end
    end

    // stage 2: squares and dot products per axis
    logic [2:0][63:0] s2_sq_reg, s2_dp_reg;
    logic [2:0][31:0] s2_ax_reg;
    logic [2:0]       s2_xneg_reg, s2_diff_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                s2_sq_reg[i] <= s1_ax_reg[i] * s1_ax_reg[i];
                s2_dp_reg[i] <= s1_ax_reg[i] * s1_av_reg[i];
            end
            s2_ax_reg   <= s1_ax_reg;
            s2_xneg_reg <= s1_xneg_reg;
            s2_diff_reg <= s1_diff_reg;
        end
    end

    // stage 3: r^2 and the signed dot product halves
    logic [63:0] s3_r2_next, s3_pos_next, s3_neg_next;
    logic [63:0] s3_r2_reg, s3_pos_reg, s3_neg_reg;
    ofs_t        s3_ofs_reg;

    always_comb begin
        s3_r2_next  = s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
        s3_pos_next = '0;
        s3_neg_next = '0;
        for (int i = 0; i < 3; i++) begin
            if (s2_diff_reg[i]) s3_neg_next = s3_neg_next + s2_dp_reg[i];
            else s3_pos_next = s3_pos_next + s2_dp_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s3_r2_reg       <= s3_r2_next;
            s3_pos_reg      <= s3_pos_next;
            s3_neg_reg      <= s3_neg_next;
            s3_ofs_reg.ax   <= s2_ax_reg;
            s3_ofs_reg.xneg <= s2_xneg_reg;
        end
    end

    // stage 4: denominator and dot magnitude
    logic [63:0] s4_denom_reg, s4_dmag_reg, s4_r2_reg;
    logic        s4_cneg_reg;
    ofs_t        s4_ofs_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s4_denom_reg <= s3_r2_reg + eps_reg;
            s4_cneg_reg  <= s3_neg_reg > s3_pos_reg;
            s4_dmag_reg  <= (s3_neg_reg > s3_pos_reg) ? s3_neg_reg - s3_pos_reg
                                                      : s3_pos_reg - s3_neg_reg;
            s4_r2_reg    <= s3_r2_reg;
            s4_ofs_reg   <= s3_ofs_reg;
        end
    end

    // distance root and coefficient divide, one digit per stage
    bst_t        b_next [BST];
    bst_t        b_reg  [BST];
    logic [63:0] b_nfull;

    always_comb begin
        b_nfull         = s4_dmag_reg << FRAC_BITS;
        b_next[0].ofs   = s4_ofs_reg;
        b_next[0].cneg  = s4_cneg_reg;
        b_next[0].czero = s4_denom_reg == '0;
        b_next[0].csat  = (s4_dmag_reg >> SH_C) >= s4_denom_reg;
        b_next[0].nlow  = b_nfull[30:0];
        b_next[0].denom = s4_denom_reg;
        b_next[0].crem  = s4_dmag_reg >> SH_C;
        b_next[0].cq    = '0;
        b_next[0].r2    = s4_r2_reg;
        b_next[0].sq    = sqrt_step('0, s4_r2_reg[63:62]);
        for (int unsigned k = 1; k < BST; k++) begin
            b_next[k] = b_step(b_reg[k-1], k);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < BST; k++) b_reg[k] <= b_next[k];
        end
    end

    // coefficient result, support test and q = r / h divide
    qst_t        q_next [QST];
    qst_t        q_reg  [QST];
    logic [30:0] c_cmag;

    always_comb begin
        c_cmag = b_reg[BST-1].czero ? '0 : (b_reg[BST-1].csat ? '1 : b_reg[BST-1].cq);
        q_next[0].side.ofs     = b_reg[BST-1].ofs;
        q_next[0].side.cmag    = c_cmag;
        q_next[0].side.cneg    = b_reg[BST-1].cneg && (c_cmag != '0);
        q_next[0].side.r       = b_reg[BST-1].sq.root;
        q_next[0].side.inrange = (b_reg[BST-1].sq.root != '0)
                              && (b_reg[BST-1].sq.root <= {1'b0, h_reg});
        q_next[0].qrem         = {1'b0, b_reg[BST-1].sq.root[31:1]};
        q_next[0].q            = '0;
        for (int unsigned k = 1; k < QST; k++) begin
            q_next[k] = q_step(q_reg[k-1], (k == 1) ? q_reg[k-1].side.r[0] : 1'b0, h_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < QST; k++) q_reg[k] <= q_next[k];
        end
    end

    // kernel shape operands, product, then scaling by the gradient coefficient
    logic [30:0] m1_q;
    logic        m1_low;
    logic [32:0] m1_q3;
    logic [29:0] m1_a_next, m1_a_reg;
    logic [31:0] m1_b_next, m1_b_reg;
    side_t       m1_side_reg, m2_side_reg, m3_side_reg;
    logic [61:0] m2_prod;
    logic [28:0] m2_m_reg;
    logic [60:0] m3_gp;
    logic [63:0] m3_p_reg;

    always_comb begin
        m1_q      = q_reg[QST-1].q;
        m1_low    = m1_q < 31'h2000_0000;
        m1_q3     = {2'b00, m1_q} + {1'b0, m1_q, 1'b0};
        m1_a_next = m1_low ? m1_q[29:0] : 30'(31'h4000_0000 - m1_q);
        m1_b_next = m1_low ? 32'(33'h0_8000_0000 - m1_q3) : {2'b00, m1_a_next};
        m2_prod   = m1_a_reg * m1_b_reg;
        m3_gp     = gc_reg * m2_m_reg;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m1_a_reg    <= m1_a_next;
            m1_b_reg    <= m1_b_next;
            m1_side_reg <= q_reg[QST-1].side;
            m2_m_reg    <= m2_prod[58:30];
            m2_side_reg <= m1_side_reg;
            m3_p_reg    <= 64'(m3_gp >> SH_K);
            m3_side_reg <= m2_side_reg;
        end
    end

    // kernel factor divided by r, saturated
    kst_t k_next [KST];
    kst_t k_reg  [KST];

    always_comb begin
        k_next[0].side = m3_side_reg;
        k_next[0].plow = m3_p_reg[31:0];
        k_next[0].ksat = m3_p_reg[63:32] >= m3_side_reg.r;
        k_next[0].krem = m3_p_reg[63:32];
        k_next[0].kq   = '0;
        for (int unsigned k = 1; k < KST; k++) begin
            k_next[k] = k_step(k_reg[k-1], k);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < KST; k++) k_reg[k] <= k_next[k];
        end
    end

    // force components: scale by kernel factor, then by the coefficient
    logic [31:0]      t_k;
    logic [2:0][63:0] t1_p_reg;
    side_t            t1_side_reg, t2_side_reg, t3_side_reg;
    logic [2:0][63:0] t2_sh;
    logic [2:0][31:0] t2_t_reg;
    logic [2:0][62:0] t3_u_reg;
    logic [2:0][62:0] t4_sh;
    logic [2:0][30:0] t4_fm;
    logic [2:0][30:0] t4_fm_reg;
    tail_t            t4_tail_next, t4_tail_reg, t5_tail_reg, t6_tail_reg;
    logic [2:0][61:0] t5_sq_reg;
    logic [63:0]      t6_f2_reg;

    always_comb begin
        t_k          = k_reg[KST-1].ksat ? '1 : k_reg[KST-1].kq;
        t4_tail_next.cmag = t3_side_reg.cmag;
        t4_tail_next.cneg = t3_side_reg.cneg;
        t4_tail_next.r    = t3_side_reg.r;
        for (int i = 0; i < 3; i++) begin
            t2_sh[i] = t1_p_reg[i] >> FRAC_BITS;
            t4_sh[i] = t3_u_reg[i] >> FRAC_BITS;
            t4_fm[i] = !t3_side_reg.inrange ? '0 : ((|t4_sh[i][62:31]) ? '1 : t4_sh[i][30:0]);
            t4_tail_next.frc[i] = (t3_side_reg.ofs.xneg[i] != t3_side_reg.cneg)
                                ? (~{1'b0, t4_fm[i]} + 32'd1) : {1'b0, t4_fm[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                t1_p_reg[i]  <= k_reg[KST-1].side.ofs.ax[i] * t_k;
                t2_t_reg[i]  <= (|t2_sh[i][63:32]) ? '1 : t2_sh[i][31:0];
                t3_u_reg[i]  <= t2_t_reg[i] * t2_side_reg.cmag;
                t5_sq_reg[i] <= t4_fm_reg[i] * t4_fm_reg[i];
            end
            t1_side_reg <= k_reg[KST-1].side;
            t2_side_reg <= t1_side_reg;
            t3_side_reg <= t2_side_reg;
            t4_fm_reg   <= t4_fm;
            t4_tail_reg <= t4_tail_next;
            t5_tail_reg <= t4_tail_reg;
            t6_f2_reg   <= 64'(t5_sq_reg[0]) + 64'(t5_sq_reg[1]) + 64'(t5_sq_reg[2]);
            t6_tail_reg <= t5_tail_reg;
        end
    end

    // force norm root
    rst_t r_next [RST];
    rst_t r_reg  [RST];

    always_comb begin
        r_next[0].tail = t6_tail_reg;
        r_next[0].f2   = t6_f2_reg;
        r_next[0].sq   = sqrt_step('0, t6_f2_reg[63:62]);
        for (int unsigned k = 1; k < RST; k++) begin
            r_next[k]    = r_reg[k-1];
            r_next[k].sq = sqrt_step(r_reg[k-1].sq, r_reg[k-1].f2[6'(63 - 2 * k) -: 2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < RST; k++) r_reg[k] <= r_next[k];
        end
    end

    // result item packing
    logic [30:0]  o_fmag, o_dist;
    logic [31:0]  o_dot;
    logic [191:0] o_item;

    always_comb begin
        o_fmag = r_reg[RST-1].sq.root[31] ? '1 : r_reg[RST-1].sq.root[30:0];
        o_dist = r_reg[RST-1].tail.r[31] ? '1 : r_reg[RST-1].tail.r[30:0];
        o_dot  = r_reg[RST-1].tail.cneg ? (~{1'b0, r_reg[RST-1].tail.cmag} + 32'd1)
                                        : {1'b0, r_reg[RST-1].tail.cmag};
        o_item = {2'b00, o_dot, o_dist, o_fmag, r_reg[RST-1].tail.frc[2],
                  r_reg[RST-1].tail.frc[1], r_reg[RST-1].tail.frc[0]};
    end

    // output register with one skid entry
    logic         m_vld_reg, skid_vld_reg;
    logic [191:0] m_data_reg, skid_data_reg;

    assign pipe_en  = !skid_vld_reg;
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (m_vld_reg && !m_tready) begin
            if (pipe_out) begin
                skid_vld_reg  <= 1'b1;
                skid_data_reg <= o_item;
            end
        end else if (skid_vld_reg) begin
            m_vld_reg    <= 1'b1;
            m_data_reg   <= skid_data_reg;
            skid_vld_reg <= 1'b0;
        end else begin
            m_vld_reg  <= pipe_out;
            m_data_reg <= o_item;
        end
    end

endmodule
